FILE: hdl/tsds_pkg.sv
package tsds_pkg;

  // Item kinds carried in tuser
  typedef enum logic {
    OP_WRITE = 1'b0,
    OP_SHADE = 1'b1
  } opcode_t;

  // Configuration register indexes
  typedef enum logic [1:0] {
    REG_SCALE_U    = 2'd0,
    REG_SCALE_V    = 2'd1,
    REG_TEX_WIDTH  = 2'd2,
    REG_TEX_HEIGHT = 2'd3
  } cfg_reg_t;

  localparam int unsigned COORD_W    = 24;
  localparam int unsigned SCALE_W    = 16;
  localparam int unsigned SIZE_W     = 9;
  localparam int unsigned VEC_W      = 16;
  localparam int unsigned LIGHT_W    = 16;
  localparam int unsigned CH_W       = 8;
  localparam int unsigned TEXEL_W    = 24;
  localparam int unsigned ADDR_IN_W  = 16;
  localparam int unsigned COS_W      = 15;
  localparam int unsigned IDX_W      = 19;
  localparam int unsigned CFG_W      = 16;
  localparam int unsigned IN_DATA_W  = 232;
  localparam int unsigned OUT_DATA_W = 24;

  // Cosine of 1.0 in Q1.14
  localparam logic [COS_W-1:0] COS_ONE = 15'd16384;

endpackage

FILE: hdl/texture_sample_diffuse_shade.sv
// A shade item reaches out_* through the stage 1 to 5 and output registers.
// Throughput: one item per cycle; the six-stage pipe halts as a whole while a
// result waits on out_tready. Write and shade items share the single texture
// memory port in stage 4, so both kinds go through the pipe in order.
// Reset (rst_n, synchronous): clears the pipe and sets the scales to 1.0 and
// the texture size to 256 x 256; texture memory contents stay undefined.
module texture_sample_diffuse_shade #(
  parameter int TEX_ENTRIES = 65536
) (
  input  logic                                clk,
  input  logic                                rst_n,
  input  logic                                in_tvalid,
  output logic                                in_tready,
  // tex_u[23:0], tex_v[47:24], normal_xyz[95:48], incoming_xyz[143:96],
  // light_rgb[191:144], texel_address[207:192], texel_rgb[231:208]
  input  logic [tsds_pkg::IN_DATA_W-1:0]      in_tdata,
  // opcode[0]
  input  logic                                in_tuser,
  output logic                                out_tvalid,
  input  logic                                out_tready,
  // red[7:0], green[15:8], blue[23:16]
  output logic [tsds_pkg::OUT_DATA_W-1:0]     out_tdata,
  input  logic                                cfg_we,
  input  logic [1:0]                          cfg_index,
  input  logic [tsds_pkg::CFG_W-1:0]          cfg_data
);
  import tsds_pkg::*;

  localparam int AW = (TEX_ENTRIES > 1) ? $clog2(TEX_ENTRIES) : 1;
  localparam int EW = ((AW > IDX_W) ? AW : IDX_W) + 1;

  // Configuration registers
  logic [SCALE_W-1:0] scale_u_r, scale_v_r;
  logic [SIZE_W-1:0]  tex_width_r, tex_height_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      scale_u_r    <= 16'd256;
      scale_v_r    <= 16'd256;
      tex_width_r  <= 9'd256;
      tex_height_r <= 9'd256;
    end else if (cfg_we) begin
      unique case (cfg_reg_t'(cfg_index))
        REG_SCALE_U:    scale_u_r    <= cfg_data;
        REG_SCALE_V:    scale_v_r    <= cfg_data;
        REG_TEX_WIDTH:  tex_width_r  <= cfg_data[SIZE_W-1:0];
        REG_TEX_HEIGHT: tex_height_r <= cfg_data[SIZE_W-1:0];
        default: ;
      endcase
    end
  end

  // Whole pipe advances when the output register is free or being drained
  logic en;
  logic out_valid_r;
  assign en        = !out_valid_r || out_tready;
  assign in_tready = en;

  // Input fields
  logic signed [COORD_W-1:0] tex_u, tex_v;
  logic [3*VEC_W-1:0]        normal_xyz, incoming_xyz;
  logic [3*LIGHT_W-1:0]      light_rgb;
  logic [ADDR_IN_W-1:0]      texel_address;
  logic [TEXEL_W-1:0]        texel_rgb;

  assign tex_u         = in_tdata[23:0];
  assign tex_v         = in_tdata[47:24];
  assign normal_xyz    = in_tdata[95:48];
  assign incoming_xyz  = in_tdata[143:96];
  assign light_rgb     = in_tdata[191:144];
  assign texel_address = in_tdata[207:192];
  assign texel_rgb     = in_tdata[231:208];

  // Stage 1: coordinate scaling and dot product terms
  logic signed [40:0] prod_u_nxt, prod_v_nxt;
  logic signed [31:0] dp_nxt [3];

  always_comb begin
    prod_u_nxt = tex_u * $signed({1'b0, scale_u_r});
    prod_v_nxt = tex_v * $signed({1'b0, scale_v_r});
    for (int k = 0; k < 3; k++) begin
      dp_nxt[k] = $signed(normal_xyz[16*k +: 16]) * $signed(incoming_xyz[16*k +: 16]);
    end
  end

  logic                  v1_r;
  opcode_t               op1_r;
  logic [COORD_W-1:0]    frac_u1_r, frac_v1_r;
  logic signed [31:0]    dp1_r [3];
  logic [3*LIGHT_W-1:0]  light1_r;
  logic [ADDR_IN_W-1:0]  addr1_r;
  logic [TEXEL_W-1:0]    wdata1_r;

  // Stage 2: texel column and row, clamped cosine
  logic [32:0]        pu_nxt, pv_nxt;
  logic signed [33:0] dsum_nxt;
  logic [COS_W-1:0]   cos2_nxt;

  always_comb begin
    pu_nxt   = frac_u1_r * tex_width_r;
    pv_nxt   = frac_v1_r * tex_height_r;
    dsum_nxt = 34'(dp1_r[0]) + 34'(dp1_r[1]) + 34'(dp1_r[2]);
    if (dsum_nxt < 34'sd0) begin
      cos2_nxt = '0;
    end else if (dsum_nxt > 34'sd268435456) begin
      cos2_nxt = COS_ONE;
    end else begin
      cos2_nxt = dsum_nxt[28:14];
    end
  end

  logic                  v2_r;
  opcode_t               op2_r;
  logic [SIZE_W-1:0]     col2_r, row2_r;
  logic [COS_W-1:0]      cos2_r;
  logic [3*LIGHT_W-1:0]  light2_r;
  logic [ADDR_IN_W-1:0]  addr2_r;
  logic [TEXEL_W-1:0]    wdata2_r;

  // Stage 3: linear address and range check
  logic [2*SIZE_W-1:0] rw_nxt;
  logic [IDX_W-1:0]    idx_nxt;
  logic [EW-1:0]       ext_nxt;
  logic                ok3_nxt;

  always_comb begin
    rw_nxt  = row2_r * tex_width_r;
    idx_nxt = {1'b0, rw_nxt} + {{(IDX_W-SIZE_W){1'b0}}, col2_r};
    if (op2_r == OP_WRITE) begin
      ext_nxt = EW'(addr2_r);
    end else begin
      ext_nxt = EW'(idx_nxt);
    end
    ok3_nxt = ext_nxt < EW'(TEX_ENTRIES);
  end

  logic                  v3_r;
  opcode_t               op3_r;
  logic [AW-1:0]         addr3_r;
  logic                  ok3_r;
  logic [TEXEL_W-1:0]    wdata3_r;
  logic [COS_W-1:0]      cos3_r;
  logic [3*LIGHT_W-1:0]  light3_r;

  // Stage 4: texture memory access (write or read, one per cycle while the pipe advances)
  logic [TEXEL_W-1:0] tex_mem [TEX_ENTRIES];
  logic [TEXEL_W-1:0] rd4_r;

  always_ff @(posedge clk) begin
    if (en && v3_r) begin
      if (op3_r == OP_WRITE) begin
        if (ok3_r) begin
          tex_mem[addr3_r] <= wdata3_r;
        end
      end else begin
        rd4_r <= tex_mem[addr3_r];
      end
    end
  end

  logic                  v4_r;
  logic                  ok4_r;
  logic [COS_W-1:0]      cos4_r;
  logic [3*LIGHT_W-1:0]  light4_r;

  // Stage 5: light times texel per channel
  logic [TEXEL_W-1:0] texel_nxt;
  logic [23:0]        lt_nxt [3];

  always_comb begin
    texel_nxt = ok4_r ? rd4_r : '0;
    for (int k = 0; k < 3; k++) begin
      lt_nxt[k] = light4_r[16*k +: 16] * texel_nxt[8*k +: 8];
    end
  end

  logic               v5_r;
  logic [23:0]        lt5_r [3];
  logic [COS_W-1:0]   cos5_r;

  // Stage 6: scale by cosine, shift and saturate
  logic [38:0]           sh_nxt [3];
  logic [OUT_DATA_W-1:0] out_nxt;

  always_comb begin
    for (int k = 0; k < 3; k++) begin
      sh_nxt[k] = lt5_r[k] * cos5_r;
      out_nxt[8*k +: 8] = (|sh_nxt[k][38:30]) ? 8'hFF : sh_nxt[k][29:22];
    end
  end

  logic [OUT_DATA_W-1:0] out_data_r;

  // Pipe valid bits
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v1_r        <= 1'b0;
      v2_r        <= 1'b0;
      v3_r        <= 1'b0;
      v4_r        <= 1'b0;
      v5_r        <= 1'b0;
      out_valid_r <= 1'b0;
    end else if (en) begin
      v1_r        <= in_tvalid;
      v2_r        <= v1_r;
      v3_r        <= v2_r;
      v4_r        <= v3_r && (op3_r == OP_SHADE);
      v5_r        <= v4_r;
      out_valid_r <= v5_r;
    end
  end

  // Pipe payload
  always_ff @(posedge clk) begin
    if (en) begin
      op1_r     <= opcode_t'(in_tuser);
      frac_u1_r <= prod_u_nxt[COORD_W-1:0];
      frac_v1_r <= prod_v_nxt[COORD_W-1:0];
      for (int k = 0; k < 3; k++) begin
        dp1_r[k] <= dp_nxt[k];
      end
      light1_r  <= light_rgb;
      addr1_r   <= texel_address;
      wdata1_r  <= texel_rgb;

      op2_r     <= op1_r;
      col2_r    <= pu_nxt[32:24];
      row2_r    <= pv_nxt[32:24];
      cos2_r    <= cos2_nxt;
      light2_r  <= light1_r;
      addr2_r   <= addr1_r;
      wdata2_r  <= wdata1_r;

      op3_r     <= op2_r;
      addr3_r   <= ext_nxt[AW-1:0];
      ok3_r     <= ok3_nxt;
      wdata3_r  <= wdata2_r;
      cos3_r    <= cos2_r;
      light3_r  <= light2_r;

      ok4_r     <= ok3_r;
      cos4_r    <= cos3_r;
      light4_r  <= light3_r;

      for (int k = 0; k < 3; k++) begin
        lt5_r[k] <= lt_nxt[k];
      end
      cos5_r    <= cos4_r;

      out_data_r <= out_nxt;
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = out_data_r;

  // Shade item in stage 3 reaches the memory read stage on advance
  a_shade_reads: assert property (@(posedge clk) disable iff (!rst_n)
    (en && v3_r && op3_r == OP_SHADE) |=> v4_r)
    else $error("shade item lost at memory stage");

  // Write items never reach the shading stages
  a_write_drops: assert property (@(posedge clk) disable iff (!rst_n)
    (en && v3_r && op3_r == OP_WRITE) |=> !v4_r)
    else $error("write item produced a result");

  // Clamped cosine never exceeds 1.0
  a_cos_range: assert property (@(posedge clk) disable iff (!rst_n)
    v3_r |-> (cos3_r <= COS_ONE))
    else $error("cosine out of range");

  // Last stage always lands in the output register
  a_out_load: assert property (@(posedge clk) disable iff (!rst_n)
    (en && v5_r) |=> out_valid_r)
    else $error("result dropped at output register");

endmodule

FILE: sim/tb_top.sv
`timescale 1ns / 1ps

module tb_top;
  import tsds_pkg::*;

  localparam int TEX_DEPTH    = 65536;
  localparam int IDLE_LIMIT   = 2000;
  localparam int DRAIN_CYCLES = 12;
  localparam int LONG_HOLD    = 400;

  // One input item, fields as the block sees them
  typedef struct packed {
    opcode_t                op;
    logic [COORD_W-1:0]     u;
    logic [COORD_W-1:0]     v;
    logic [3*VEC_W-1:0]     normal;
    logic [3*VEC_W-1:0]     incoming;
    logic [3*LIGHT_W-1:0]   light;
    logic [ADDR_IN_W-1:0]   addr;
    logic [TEXEL_W-1:0]     rgb;
  } hit_item_t;

  // One shaded pixel, laid out as out_tdata
  typedef struct packed {
    logic [CH_W-1:0] blue;
    logic [CH_W-1:0] green;
    logic [CH_W-1:0] red;
  } pixel_t;

  logic                  clk = 1'b0;
  logic                  rst_n = 1'b0;
  logic                  in_tvalid = 1'b0;
  logic                  in_tready;
  logic [IN_DATA_W-1:0]  in_tdata = '0;
  logic                  in_tuser = 1'b0;
  logic                  out_tvalid;
  logic                  out_tready = 1'b0;
  logic [OUT_DATA_W-1:0] out_tdata;
  logic                  cfg_we = 1'b0;
  logic [1:0]            cfg_index = '0;
  logic [CFG_W-1:0]      cfg_data = '0;

  texture_sample_diffuse_shade uut (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .in_tuser   (in_tuser),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .cfg_we     (cfg_we),
    .cfg_index  (cfg_index),
    .cfg_data   (cfg_data)
  );

  initial forever #10 clk = ~clk;

  // Shader state mirror: registers and texture contents
  logic [SCALE_W-1:0] scale_u_q = 16'd256;
  logic [SCALE_W-1:0] scale_v_q = 16'd256;
  logic [SIZE_W-1:0]  width_q   = 9'd256;
  logic [SIZE_W-1:0]  height_q  = 9'd256;
  logic [TEXEL_W-1:0] texels [TEX_DEPTH];
  bit                 texel_known [TEX_DEPTH];

  hit_item_t pending_items[$];
  pixel_t    expected_pixels[$];

  int items_queued    = 0;
  int items_accepted  = 0;
  int shades_accepted = 0;
  int writes_accepted = 0;
  int pixels_checked  = 0;
  int mismatches      = 0;
  int settings_used   = 0;
  int long_holds      = 0;

  // Repeat-wrapped texel position along one axis
  function automatic logic [63:0] wrap_index(input logic [COORD_W-1:0] coord,
                                             input logic [SCALE_W-1:0] scale,
                                             input logic [SIZE_W-1:0]  size);
    longint     prod;
    logic [63:0] frac;
    prod = longint'($signed(coord)) * longint'(scale);
    frac = {40'd0, prod[23:0]};
    return (frac * 64'(size)) >> 24;
  endfunction

  function automatic logic [63:0] texel_index(input logic [COORD_W-1:0] u,
                                              input logic [COORD_W-1:0] v);
    return wrap_index(v, scale_v_q, height_q) * 64'(width_q) +
           wrap_index(u, scale_u_q, width_q);
  endfunction

  // Nearest texel times light times clamped cosine, saturated per channel
  function automatic pixel_t shade_pixel(input hit_item_t it);
    logic [63:0]        idx;
    logic [63:0]        cosv;
    logic [63:0]        prod;
    logic [TEXEL_W-1:0] texel;
    logic [CH_W-1:0]    ch [3];
    longint             dot;
    pixel_t             p;
    idx   = texel_index(it.u, it.v);
    texel = (idx < TEX_DEPTH) ? texels[idx[15:0]] : '0;
    dot = 0;
    for (int k = 0; k < 3; k++)
      dot += longint'($signed(it.normal[16*k +: 16])) *
             longint'($signed(it.incoming[16*k +: 16]));
    if (dot < 0) dot = 0;
    if (dot > (longint'(1) << 28)) dot = longint'(1) << 28;
    cosv = 64'(dot) >> 14;
    for (int k = 0; k < 3; k++) begin
      prod  = (64'(it.light[16*k +: 16]) * 64'(texel[8*k +: 8]) * cosv) >> 22;
      ch[k] = (prod > 64'd255) ? 8'hFF : prod[7:0];
    end
    p.red   = ch[0];
    p.green = ch[1];
    p.blue  = ch[2];
    return p;
  endfunction

  // Random field sources
  function automatic logic [COORD_W-1:0] rand_coord();
    case ($urandom_range(0, 15))
      0: return 24'h800000;
      1: return 24'h7FFFFF;
      2: return 24'hFFFFFF;
      3: return 24'h000000;
      default: return 24'($urandom);
    endcase
  endfunction

  function automatic logic [3*VEC_W-1:0] rand_vec();
    logic [3*VEC_W-1:0] v;
    for (int k = 0; k < 3; k++) begin
      case ($urandom_range(0, 3))
        0: v[16*k +: 16] = 16'($urandom);
        3: begin
          case ($urandom_range(0, 4))
            0: v[16*k +: 16] = 16'h4000;
            1: v[16*k +: 16] = 16'hC000;
            2: v[16*k +: 16] = 16'h7FFF;
            3: v[16*k +: 16] = 16'h8000;
            default: v[16*k +: 16] = 16'h0000;
          endcase
        end
        default: v[16*k +: 16] = 16'($urandom_range(0, 32768) - 16384);
      endcase
    end
    return v;
  endfunction

  function automatic logic [3*LIGHT_W-1:0] rand_light();
    logic [3*LIGHT_W-1:0] lt;
    for (int k = 0; k < 3; k++) begin
      case ($urandom_range(0, 9))
        0, 1:    lt[16*k +: 16] = 16'($urandom);
        2, 3, 4: lt[16*k +: 16] = 16'($urandom_range(0, 16'h0FFF));
        default: lt[16*k +: 16] = 16'($urandom_range(0, 16'h0200));
      endcase
    end
    return lt;
  endfunction

  function automatic hit_item_t random_hit();
    hit_item_t it;
    it.op       = OP_SHADE;
    it.u        = rand_coord();
    it.v        = rand_coord();
    it.normal   = rand_vec();
    it.incoming = rand_vec();
    it.light    = rand_light();
    it.addr     = 16'($urandom);
    it.rgb      = 24'($urandom);
    return it;
  endfunction

  // Address mostly inside the area the current size can reach
  function automatic logic [ADDR_IN_W-1:0] region_addr();
    int unsigned span;
    span = int'(width_q) * int'(height_q);
    if (span == 0 || span > TEX_DEPTH || $urandom_range(0, 2) == 0)
      return 16'($urandom);
    return 16'($urandom_range(0, span - 1));
  endfunction

  function automatic void queue_item(input hit_item_t it);
    pending_items.push_back(it);
    items_queued++;
    if (it.op == OP_WRITE) texel_known[it.addr] = 1'b1;
  endfunction

  function automatic void queue_write(input logic [ADDR_IN_W-1:0] addr,
                                      input logic [TEXEL_W-1:0] rgb);
    hit_item_t it;
    it      = random_hit();
    it.op   = OP_WRITE;
    it.addr = addr;
    it.rgb  = rgb;
    queue_item(it);
  endfunction

  // Shade items only ever read texels that have been written
  function automatic void queue_shade(input hit_item_t it);
    logic [63:0] idx;
    idx = texel_index(it.u, it.v);
    if (idx < TEX_DEPTH && !texel_known[idx[15:0]])
      queue_write(idx[15:0], 24'($urandom));
    it.op = OP_SHADE;
    queue_item(it);
  endfunction

  function automatic void queue_hit(input logic [COORD_W-1:0] u,
                                    input logic [COORD_W-1:0] v,
                                    input logic [3*VEC_W-1:0] n,
                                    input logic [3*VEC_W-1:0] l,
                                    input logic [3*LIGHT_W-1:0] lt);
    hit_item_t it;
    it          = random_hit();
    it.u        = u;
    it.v        = v;
    it.normal   = n;
    it.incoming = l;
    it.light    = lt;
    queue_shade(it);
  endfunction

  // Mix of realistic shades, texel writes and raw noise shades
  function automatic void queue_random(input int count);
    hit_item_t it;
    int        r;
    for (int i = 0; i < count; i++) begin
      r = $urandom_range(0, 99);
      if (r < 50) begin
        queue_shade(random_hit());
      end else if (r < 90) begin
        queue_write(region_addr(), 24'($urandom));
      end else begin
        it          = random_hit();
        it.normal   = {16'($urandom), 32'($urandom)};
        it.incoming = {16'($urandom), 32'($urandom)};
        it.light    = {16'($urandom), 32'($urandom)};
        queue_shade(it);
      end
    end
  endfunction

  // Idle length: mostly short, now and then long
  function automatic int idle_len();
    int r;
    r = $urandom_range(0, 99);
    if (r < 70) return $urandom_range(1, 2);
    if (r < 95) return $urandom_range(3, 8);
    return $urandom_range(20, 60);
  endfunction

  task automatic wait_idle();
    while (items_accepted != items_queued || expected_pixels.size() != 0)
      @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  task automatic program_regs(input logic [SCALE_W-1:0] su, input logic [SCALE_W-1:0] sv,
                              input logic [SIZE_W-1:0] w, input logic [SIZE_W-1:0] h);
    @(posedge clk);
    cfg_we    <= 1'b1;
    cfg_index <= REG_SCALE_U;
    cfg_data  <= su;
    scale_u_q  = su;
    @(posedge clk);
    cfg_index <= REG_SCALE_V;
    cfg_data  <= sv;
    scale_v_q  = sv;
    @(posedge clk);
    cfg_index <= REG_TEX_WIDTH;
    cfg_data  <= 16'(w);
    width_q    = w;
    @(posedge clk);
    cfg_index <= REG_TEX_HEIGHT;
    cfg_data  <= 16'(h);
    height_q   = h;
    @(posedge clk);
    cfg_we    <= 1'b0;
    settings_used++;
  endtask

  task automatic run_phase(input logic [SCALE_W-1:0] su, input logic [SCALE_W-1:0] sv,
                           input logic [SIZE_W-1:0] w, input logic [SIZE_W-1:0] h,
                           input int count);
    wait_idle();
    program_regs(su, sv, w, h);
    queue_random(count);
  endtask

  // Sender: present queued items, random gaps between them
  hit_item_t offered;
  int        send_gap  = 0;
  int        send_calm = 0;

  always @(posedge clk) begin
    if (!rst_n) begin
      in_tvalid <= 1'b0;
    end else begin
      if (in_tvalid && in_tready) begin
        if (offered.op == OP_WRITE) begin
          texels[offered.addr] = offered.rgb;
          writes_accepted++;
        end else begin
          expected_pixels.push_back(shade_pixel(offered));
          shades_accepted++;
        end
        items_accepted++;
      end
      if (!in_tvalid || in_tready) begin
        if (send_gap > 0) begin
          send_gap--;
          in_tvalid <= 1'b0;
        end else if (pending_items.size() != 0) begin
          offered = pending_items.pop_front();
          in_tdata  <= {offered.rgb, offered.addr, offered.light, offered.incoming,
                        offered.normal, offered.v, offered.u};
          in_tuser  <= offered.op;
          in_tvalid <= 1'b1;
          if (send_calm > 0) begin
            send_calm--;
            send_gap = 0;
          end else if ($urandom_range(0, 99) < 2) begin
            send_calm = $urandom_range(20, 80);
            send_gap  = 0;
          end else if ($urandom_range(0, 99) < 45) begin
            send_gap = 0;
          end else begin
            send_gap = idle_len();
          end
        end else begin
          in_tvalid <= 1'b0;
        end
      end
    end
  end

  // Receiver: compare each pixel with the oldest prediction, stall at random
  int     sink_stall = 0;
  int     sink_calm  = 0;
  pixel_t got;
  pixel_t want;

  always @(posedge clk) begin
    if (!rst_n) begin
      out_tready <= 1'b0;
    end else begin
      if (out_tvalid && out_tready) begin
        got = pixel_t'(out_tdata);
        pixels_checked++;
        if (expected_pixels.size() == 0) begin
          $display("%0t: pixel %h arrived with none pending", $time, got);
          mismatches++;
        end else begin
          want = expected_pixels.pop_front();
          if (got.red !== want.red) begin
            $display("%0t: red expected %0d actual %0d", $time, want.red, got.red);
            mismatches++;
          end
          if (got.green !== want.green) begin
            $display("%0t: green expected %0d actual %0d", $time, want.green, got.green);
            mismatches++;
          end
          if (got.blue !== want.blue) begin
            $display("%0t: blue expected %0d actual %0d", $time, want.blue, got.blue);
            mismatches++;
          end
        end
      end
      if (sink_stall > 0) begin
        sink_stall--;
        out_tready <= 1'b0;
      end else if (long_holds < 2 && pixels_checked >= 150 + 300 * long_holds &&
                   pending_items.size() > 20) begin
        // hold off long enough for the pipe to fill and back up the input
        long_holds++;
        sink_stall = LONG_HOLD;
        out_tready <= 1'b0;
      end else if (sink_calm > 0) begin
        sink_calm--;
        out_tready <= 1'b1;
      end else if ($urandom_range(0, 99) < 2) begin
        sink_calm = $urandom_range(20, 80);
        out_tready <= 1'b1;
      end else if ($urandom_range(0, 99) < 25) begin
        sink_stall = idle_len() - 1;
        out_tready <= 1'b0;
      end else begin
        out_tready <= 1'b1;
      end
    end
  end

  // Watchdog: end the run when nothing moves for too long
  int idle_cycles = 0;

  always @(posedge clk) begin
    if (!rst_n || (in_tvalid && in_tready) || (out_tvalid && out_tready)) begin
      idle_cycles <= 0;
    end else if (idle_cycles == IDLE_LIMIT) begin
      $display("%0t: no item moved for %0d cycles", $time, IDLE_LIMIT);
      $display("[FAIL] regression broken");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

  // Stimulus plan
  initial begin
    repeat (11) @(posedge clk);
    rst_n <= 1'b1;

    // Directed items at reset settings: 1.0 scales, 256 x 256 texture
    queue_write(16'h0000, 24'hFFFFFF);
    queue_write(16'hFFFF, 24'h80FF01);
    // full cosine, brightest light: saturate
    queue_hit(24'h000000, 24'h000000, {32'h0, 16'h4000}, {32'h0, 16'h4000},
              48'hFFFF_FFFF_FFFF);
    // a negative u and the largest positive v wrap to the last texel
    queue_hit(24'hFFFFFF, 24'h7FFFFF, {16'h0, 16'h4000, 16'h0}, {16'h0, 16'h4000, 16'h0},
              {3{16'h0100}});
    // light behind the surface
    queue_hit(24'h800000, 24'h800000, {32'h0, 16'h4000}, {32'h0, 16'hC000},
              {3{16'h0100}});
    // dot product above one clamps
    queue_hit(24'h000000, 24'h000000, {16'h0, 16'h4000, 16'h4000},
              {16'h0, 16'h4000, 16'h4000}, {3{16'h0080}});
    queue_hit(24'h000000, 24'h000000, {3{16'h8000}}, {3{16'h8000}}, {3{16'h0100}});
    queue_hit(24'hFFFFFF, 24'h7FFFFF, {3{16'h7FFF}}, {3{16'h8000}}, {3{16'hFFFF}});
    // zero vectors, then no light
    queue_hit(24'h000000, 24'h000000, 48'h0, 48'h0, {3{16'hFFFF}});
    queue_hit(24'h000000, 24'h000000, {32'h0, 16'h4000}, {32'h0, 16'h4000}, 48'h0);
    queue_hit(24'hFFFFFF, 24'h7FFFFF, {32'h0, 16'h4000}, {32'h0, 16'h2000},
              {3{16'hFFFF}});
    // overwrite one texel, then read it back
    queue_write(16'h0102, 24'h112233);
    queue_write(16'h0102, 24'h445566);
    queue_hit(24'h000200, 24'h000100, {32'h0, 16'h4000}, {32'h0, 16'h3000},
              {16'h0200, 16'h0180, 16'h0100});
    queue_hit(24'h7FFF00, 24'h80FF00, {16'h2000, 16'h2000, 16'h2000},
              {16'h2000, 16'h2000, 16'h2000}, {16'h0400, 16'h0100, 16'h0010});

    // Register settings, extremes and special cases first
    run_phase(16'h0100, 16'h0100, 9'd16,  9'd16,  70);
    run_phase(16'h0000, 16'h0000, 9'd1,   9'd1,   40);
    run_phase(16'hFFFF, 16'hFFFF, 9'd256, 9'd256, 40);
    run_phase(16'h0180, 16'h0340, 9'd13,  9'd7,   60);
    // zero width, then zero height
    run_phase(16'h0255, 16'h0100, 9'd0,   9'd5,   30);
    run_phase(16'h0100, 16'h0731, 9'd9,   9'd0,   30);
    // sizes past 256: far texels fall outside the store and read black
    run_phase(16'h0100, 16'h0100, 9'd511, 9'd300, 50);
    run_phase(16'h0001, 16'h0001, 9'd256, 9'd256, 30);
    for (int p = 0; p < 6; p++) begin
      run_phase(16'($urandom), 16'($urandom),
                ($urandom_range(0, 1) == 0) ? 9'($urandom_range(1, 16))
                                            : 9'($urandom_range(1, 256)),
                ($urandom_range(0, 1) == 0) ? 9'($urandom_range(1, 16))
                                            : 9'($urandom_range(1, 256)),
                30);
    end

    wait_idle();
    if (expected_pixels.size() != 0) begin
      $display("%0t: %0d pixels never arrived", $time, expected_pixels.size());
      mismatches++;
    end
    $display("Covered %0d items (%0d shades, %0d texel writes) over %0d register settings.",
             items_accepted, shades_accepted, writes_accepted, settings_used + 1);
    $display("Compared %0d pixels with %0d long output hold-offs; %0d mismatches.",
             pixels_checked, long_holds, mismatches);
    if (mismatches == 0) begin
      $display("[ OK ] regression clean");
    end else begin
      $display("[FAIL] regression broken");
    end
    $finish;
  end

endmodule
